### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the shallow water stencil core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### rtl/core/swsten_pkg.sv
// ----------------------------------------------------------------------------
// swsten_pkg
// Sizes, codes and fixed-point helpers of the shallow water stencil core.
// ----------------------------------------------------------------------------
package swsten_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int DEPTH     = MAX_CELLS + 2;
    localparam int IDX_W     = $clog2(DEPTH);

    localparam int CIDX_W    = 11;
    localparam int CNT_W     = 11;
    localparam int COEF_W    = 31;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int Q_W       = 32;
    localparam int FRAC      = 24;

    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int RND_W     = PROD_W - FRAC;
    localparam int SAT_W     = 44;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 96;

    localparam logic [CNT_W-1:0]  RST_CELL_COUNT = 11'd1024;
    localparam logic [COEF_W-1:0] RST_STEP_COEF  = 31'd838861;
    localparam logic [COEF_W-1:0] RST_PRESS_COEF = 31'd82540;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COEF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_COEF = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_STEP = 2'd1,
        OP_READ = 2'd2
    } t_op;

    localparam logic signed [Q_W-1:0]   Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0]   Q_MIN  = 32'sh8000_0000;
    localparam logic signed [SAT_W-1:0] SAT_HI = 44'sh000_7FFF_FFFF;
    localparam logic signed [SAT_W-1:0] SAT_LO = 44'shFFF_8000_0000;

    // Q8.24 product scaling: add one half LSB, then drop the fraction bits.
    function automatic logic signed [RND_W-1:0] qround(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + $signed({{(PROD_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}});
        return t[PROD_W-1:FRAC];
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SAT_HI) begin
            r = Q_MAX;
        end else if (v < SAT_LO) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/swsten_qmul.sv
// ----------------------------------------------------------------------------
// swsten_qmul
// Shared signed multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
module swsten_qmul (
    input  logic                                   i_clk,
    input  logic signed [swsten_pkg::MUL_W-1:0]    i_a,
    input  logic signed [swsten_pkg::MUL_W-1:0]    i_b,
    output logic signed [swsten_pkg::PROD_W-1:0]   o_prod
);
    import swsten_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/swsten_div.sv
// ----------------------------------------------------------------------------
// swsten_div
// Bit-serial restoring divider for the Q8.24 velocity quotient.
// ----------------------------------------------------------------------------
module swsten_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [swsten_pkg::Q_W-1:0]   i_num,
    input  logic signed [swsten_pkg::Q_W-1:0]   i_den,
    output logic                                o_done,
    output logic signed [swsten_pkg::Q_W-1:0]   o_quo
);
    import swsten_pkg::*;

    localparam int DIV_N_W = Q_W + FRAC;
    localparam int DCNT_W  = $clog2(DIV_N_W);
    localparam logic [DIV_N_W-1:0] LIM_NEG = DIV_N_W'(64'h8000_0000);
    localparam logic [DIV_N_W-1:0] LIM_POS = DIV_N_W'(64'h7FFF_FFFF);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} t_dstate;

    t_dstate              r_state;
    logic [DCNT_W-1:0]    r_cnt;
    logic [DIV_N_W-1:0]   r_acc;
    logic [Q_W-1:0]       r_rem;
    logic [Q_W-1:0]       r_den;
    logic                 r_neg;
    logic                 r_den_zero;
    logic                 r_num_pos;
    logic                 r_num_neg;
    logic                 r_done;
    logic signed [Q_W-1:0] r_quo;

    logic [Q_W-1:0] mag_num;
    logic [Q_W-1:0] mag_den;
    logic [Q_W:0]   shifted;
    logic           ge;
    logic [Q_W:0]   diff;

    always_comb begin
        mag_num = i_num[Q_W-1] ? (~i_num + 1'b1) : i_num;
        mag_den = i_den[Q_W-1] ? (~i_den + 1'b1) : i_den;
        shifted = {r_rem, r_acc[DIV_N_W-1]};
        ge      = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_acc      <= {mag_num, {FRAC{1'b0}}};
                        r_rem      <= '0;
                        r_den      <= mag_den;
                        r_neg      <= i_num[Q_W-1] ^ i_den[Q_W-1];
                        r_den_zero <= (i_den == '0);
                        r_num_pos  <= !i_num[Q_W-1] && (i_num != '0);
                        r_num_neg  <= i_num[Q_W-1];
                        r_cnt      <= '0;
                        r_state    <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= ge ? diff[Q_W-1:0] : shifted[Q_W-1:0];
                    r_acc <= {r_acc[DIV_N_W-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DCNT_W'(DIV_N_W - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    // The shift register now holds the magnitude of the quotient.
                    if (r_den_zero) begin
                        r_quo <= r_num_pos ? Q_MAX : (r_num_neg ? Q_MIN : '0);
                    end else if (r_neg) begin
                        r_quo <= (r_acc > LIM_NEG) ? Q_MIN : -$signed(r_acc[Q_W-1:0]);
                    end else begin
                        r_quo <= (r_acc > LIM_POS) ? Q_MAX : $signed(r_acc[Q_W-1:0]);
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/core/shallow_water_1d_stencil_step_top.sv
// ----------------------------------------------------------------------------
// shallow_water_1d_stencil_step_top
// One-dimensional shallow water solver, Lax-Friedrichs scheme in Q8.24.
// ----------------------------------------------------------------------------
// Commands enter on the slave stream: tuser carries the opcode (load, step,
// read) and tdata the cell index, mass and momentum. Only a read produces a
// beat on the master stream, carrying mass, momentum and velocity of a cell.
// Coefficients and the cell count are written through the plain register
// port; the user must write them only while the core is idle, which the
// block itself does not enforce. A load does not leave the idle state, so
// loads stream back to back. A read returns its beat through the pending
// and output registers, and the slave side takes nothing in the cycle after
// a read, so reads cannot stream back to back. A step holds the core for a
// flux pass over every cell on the shared multiplier and an update pass
// bound by the bit-serial divider for each velocity.
// After reset the core zeroes all 1026 velocity memory entries and holds
// tready low meanwhile; configuration writes are accepted throughout.
// If the receiver stalls, the read result waits in the output register and
// the slave side holds tready low for every command until that beat is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shallow_water_1d_stencil_step_top (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Configuration write port.
    input  logic                                     i_cfg_we,
    input  logic [swsten_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [swsten_pkg::COEF_W-1:0]            i_cfg_wdata,
    // Command stream.
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: cell_index[10:0], mass_in[42:11], momentum_in[74:43], zero fill
    input  logic [swsten_pkg::IN_DATA_W-1:0]         i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [swsten_pkg::OP_W-1:0]              i_s_axis_tuser,
    // Result stream.
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // tdata: mass_out[31:0], momentum_out[63:32], velocity_out[95:64]
    output logic [swsten_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata
);
    import swsten_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_B0, S_B1, S_B2,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9, S_F10,
        S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_U6, S_U7
    } t_state;

    // State memories: two banks of mass and momentum, plus velocity and flux.
    logic [Q_W-1:0] mem_mass [2][DEPTH];
    logic [Q_W-1:0] mem_mom  [2][DEPTH];
    logic [Q_W-1:0] mem_vel  [DEPTH];
    logic [Q_W-1:0] mem_flux [DEPTH];

    t_state             r_state;
    logic [IDX_W-1:0]   r_x;
    logic [IDX_W-1:0]   r_n;
    logic               r_sel;
    logic [CNT_W-1:0]   r_cell_count;
    logic [COEF_W-1:0]  r_step_coef;
    logic [COEF_W-1:0]  r_press_coef;
    logic               r_rd_pend;
    logic               r_rd_zero;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic               r_div_start;

    logic signed [Q_W-1:0] r_mass_q, r_mom_q, r_vel_q, r_flux_q;
    logic signed [Q_W-1:0] r_m, r_u, r_mu, r_km, r_muu, r_kmm;
    logic signed [Q_W-1:0] r_mp, r_pp, r_fp, r_avgp, r_avgm, r_pn, r_mn;
    logic signed [MUL_W-1:0] r_dp;
    logic signed [MUL_W-1:0] r_ma, r_mb;

    logic signed [PROD_W-1:0] prod;
    logic signed [RND_W-1:0]  prod_rnd;
    logic signed [Q_W-1:0]    prod_sat;
    logic                     div_done;
    logic signed [Q_W-1:0]    div_quo;

    // Command fields.
    logic [CIDX_W-1:0]     in_idx;
    logic signed [Q_W-1:0] in_mass, in_mom;
    t_op                   in_op;
    logic                  in_accept;
    logic                  in_range;
    logic [IDX_W-1:0]      in_addr;
    logic [IDX_W-1:0]      n_clamped;

    // Memory port controls.
    logic                  rd_bank;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      vel_rd_addr;
    logic [IDX_W-1:0]      flux_rd_addr;
    logic                  mm_we, mm_bank;
    logic [IDX_W-1:0]      mm_addr;
    logic [Q_W-1:0]        mass_wd, mom_wd;
    logic                  vel_we;
    logic [IDX_W-1:0]      vel_addr;
    logic [Q_W-1:0]        vel_wd;
    logic                  flux_we;
    logic [Q_W-1:0]        flux_wd;

    // Neighbor arithmetic of the update pass.
    logic signed [Q_W:0]   sum_p, sum_m, diff_f, diff_p;
    logic signed [Q_W-1:0] neg_mom;
    logic signed [Q_W-1:0] flux_sum;

    assign in_idx    = i_s_axis_tdata[10:0];
    assign in_mass   = i_s_axis_tdata[42:11];
    assign in_mom    = i_s_axis_tdata[74:43];
    assign in_op     = t_op'(i_s_axis_tuser);
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_range  = {{(32-CIDX_W){1'b0}}, in_idx} < 32'(DEPTH);
    assign in_addr   = in_range ? IDX_W'(in_idx) : '0;

    // The cell count is clamped to the range 2 to MAX_CELLS.
    always_comb begin
        if ({{(32-CNT_W){1'b0}}, r_cell_count} < 32'd2) begin
            n_clamped = IDX_W'(2);
        end else if ({{(32-CNT_W){1'b0}}, r_cell_count} > 32'(MAX_CELLS)) begin
            n_clamped = IDX_W'(MAX_CELLS);
        end else begin
            n_clamped = IDX_W'(r_cell_count);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_rd_pend
                             && (!r_out_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    swsten_qmul u_qmul (
        .i_clk  (i_clk),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_prod (prod)
    );

    swsten_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_pn),
        .i_den   (r_mn),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign prod_rnd = qround(prod);
    assign prod_sat = sat32({{(SAT_W-RND_W){prod_rnd[RND_W-1]}}, prod_rnd});

    always_comb begin
        sum_p    = {r_pp[Q_W-1], r_pp} + {r_mom_q[Q_W-1], r_mom_q};
        sum_m    = {r_mp[Q_W-1], r_mp} + {r_mass_q[Q_W-1], r_mass_q};
        diff_f   = {r_fp[Q_W-1], r_fp} - {r_flux_q[Q_W-1], r_flux_q};
        diff_p   = {r_pp[Q_W-1], r_pp} - {r_mom_q[Q_W-1], r_mom_q};
        neg_mom  = sat32(-{{(SAT_W-Q_W){r_mom_q[Q_W-1]}}, r_mom_q});
        flux_sum = sat32({{(SAT_W-Q_W){r_muu[Q_W-1]}}, r_muu}
                         + {{(SAT_W-Q_W){r_kmm[Q_W-1]}}, r_kmm});
    end

    // Address and write steering for the memories.
    always_comb begin
        rd_bank      = r_sel;
        rd_addr      = '0;
        vel_rd_addr  = '0;
        flux_rd_addr = '0;
        mm_we        = 1'b0;
        mm_bank      = r_sel;
        mm_addr      = '0;
        mass_wd      = r_mass_q;
        mom_wd       = r_mom_q;
        vel_we       = 1'b0;
        vel_addr     = r_x;
        vel_wd       = '0;
        flux_we      = 1'b0;
        flux_wd      = flux_sum;
        case (r_state)
            S_CLR: begin
                vel_we = 1'b1;
            end
            S_IDLE: begin
                rd_addr     = in_addr;
                vel_rd_addr = in_addr;
                if (in_accept && in_op == OP_LOAD && in_range) begin
                    mm_we   = 1'b1;
                    mm_addr = in_addr;
                    mass_wd = in_mass;
                    mom_wd  = in_mom;
                end
            end
            S_B0: begin
                rd_addr = IDX_W'(2);
            end
            S_B1: begin
                // Left halo mirrors cell 2; the right source is fetched now.
                rd_addr = r_n - 1'b1;
                mm_we   = 1'b1;
                mm_addr = '0;
                mom_wd  = neg_mom;
            end
            S_B2: begin
                mm_we   = 1'b1;
                mm_addr = r_n + 1'b1;
                mom_wd  = neg_mom;
            end
            S_F0: begin
                rd_addr     = r_x;
                vel_rd_addr = r_x;
            end
            S_F10: begin
                flux_we = 1'b1;
            end
            S_U0: begin
                rd_addr      = r_x + 1'b1;
                flux_rd_addr = r_x + 1'b1;
            end
            S_U1: begin
                rd_addr      = r_x - 1'b1;
                flux_rd_addr = r_x - 1'b1;
            end
            S_U6: begin
                mm_we   = 1'b1;
                mm_bank = !r_sel;
                mm_addr = r_x;
                mass_wd = r_mn;
                mom_wd  = r_pn;
            end
            S_U7: begin
                vel_we = div_done;
                vel_wd = div_quo;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mm_we) begin
            mem_mass[mm_bank][mm_addr] <= mass_wd;
            mem_mom[mm_bank][mm_addr]  <= mom_wd;
        end
        r_mass_q <= mem_mass[rd_bank][rd_addr];
        r_mom_q  <= mem_mom[rd_bank][rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vel_we) begin
            mem_vel[vel_addr] <= vel_wd;
        end
        r_vel_q <= mem_vel[vel_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (flux_we) begin
            mem_flux[r_x] <= flux_wd;
        end
        r_flux_q <= mem_flux[flux_rd_addr];
    end

    // Sequencer and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_x          <= '0;
            r_n          <= IDX_W'(MAX_CELLS);
            r_sel        <= 1'b0;
            r_cell_count <= RST_CELL_COUNT;
            r_step_coef  <= RST_STEP_COEF;
            r_press_coef <= RST_PRESS_COEF;
            r_rd_pend    <= 1'b0;
            r_rd_zero    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_div_start  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CELL_COUNT: r_cell_count <= i_cfg_wdata[CNT_W-1:0];
                    CFG_STEP_COEF:  r_step_coef  <= i_cfg_wdata;
                    CFG_PRESS_COEF: r_press_coef <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_rd_zero ? '0 : {r_vel_q, r_mom_q, r_mass_q};
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            r_rd_pend   <= 1'b0;
            r_div_start <= 1'b0;

            case (r_state)
                S_CLR: begin
                    if (r_x == IDX_W'(DEPTH - 1)) begin
                        r_x     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        case (in_op)
                            OP_READ: begin
                                r_rd_pend <= 1'b1;
                                r_rd_zero <= !in_range;
                            end
                            OP_STEP: begin
                                r_n     <= n_clamped;
                                r_state <= S_B0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_B0: r_state <= S_B1;
                S_B1: r_state <= S_B2;
                S_B2: begin
                    r_x     <= '0;
                    r_state <= S_F0;
                end
                // Flux pass: F = (m*u)*u + (k*m)*m on the shared multiplier.
                S_F0: r_state <= S_F1;
                S_F1: begin
                    r_m     <= r_mass_q;
                    r_u     <= r_vel_q;
                    r_ma    <= {r_mass_q[Q_W-1], r_mass_q};
                    r_mb    <= {r_vel_q[Q_W-1], r_vel_q};
                    r_state <= S_F2;
                end
                S_F2: r_state <= S_F3;
                S_F3: begin
                    r_mu    <= prod_sat;
                    r_ma    <= {2'b00, r_press_coef};
                    r_mb    <= {r_m[Q_W-1], r_m};
                    r_state <= S_F4;
                end
                S_F4: r_state <= S_F5;
                S_F5: begin
                    r_km    <= prod_sat;
                    r_ma    <= {r_mu[Q_W-1], r_mu};
                    r_mb    <= {r_u[Q_W-1], r_u};
                    r_state <= S_F6;
                end
                S_F6: r_state <= S_F7;
                S_F7: begin
                    r_muu   <= prod_sat;
                    r_ma    <= {r_km[Q_W-1], r_km};
                    r_mb    <= {r_m[Q_W-1], r_m};
                    r_state <= S_F8;
                end
                S_F8: r_state <= S_F9;
                S_F9: begin
                    r_kmm   <= prod_sat;
                    r_state <= S_F10;
                end
                S_F10: begin
                    if (r_x == r_n + 1'b1) begin
                        r_x     <= IDX_W'(1);
                        r_state <= S_U0;
                    end else begin
                        r_x     <= r_x + 1'b1;
                        r_state <= S_F0;
                    end
                end
                // Update pass: neighbors x+1 then x-1, two products, one quotient.
                S_U0: r_state <= S_U1;
                S_U1: begin
                    r_mp    <= r_mass_q;
                    r_pp    <= r_mom_q;
                    r_fp    <= r_flux_q;
                    r_state <= S_U2;
                end
                S_U2: begin
                    r_avgp  <= sum_p[Q_W:1];
                    r_avgm  <= sum_m[Q_W:1];
                    r_dp    <= diff_p;
                    r_ma    <= {2'b00, r_step_coef};
                    r_mb    <= diff_f;
                    r_state <= S_U3;
                end
                S_U3: begin
                    r_ma    <= {2'b00, r_step_coef};
                    r_mb    <= r_dp;
                    r_state <= S_U4;
                end
                S_U4: begin
                    r_pn <= sat32({{(SAT_W-Q_W){r_avgp[Q_W-1]}}, r_avgp}
                                  - {{(SAT_W-RND_W){prod_rnd[RND_W-1]}}, prod_rnd});
                    r_state <= S_U5;
                end
                S_U5: begin
                    r_mn <= sat32({{(SAT_W-Q_W){r_avgm[Q_W-1]}}, r_avgm}
                                  - {{(SAT_W-RND_W){prod_rnd[RND_W-1]}}, prod_rnd});
                    r_state <= S_U6;
                end
                S_U6: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_U7;
                end
                S_U7: begin
                    if (div_done) begin
                        if (r_x == r_n) begin
                            r_sel   <= !r_sel;
                            r_state <= S_IDLE;
                        end else begin
                            r_x     <= r_x + 1'b1;
                            r_state <= S_U0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_busy_holds_input, i_clk, i_rst_n, r_state != S_IDLE, !o_s_axis_tready)
    `ASSERT_NEXT(a_read_gives_beat, i_clk, i_rst_n, r_rd_pend, o_m_axis_tvalid)
    `ASSERT_IMPLIES(a_read_slot_free, i_clk, i_rst_n, r_rd_pend, !r_out_valid)
    `ASSERT_IMPLIES(a_div_only_in_update, i_clk, i_rst_n, r_div_start, r_state == S_U7)

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 1D shallow water Lax-Friedrichs stencil core.
// ----------------------------------------------------------------------------
// A short directed table covers field extremes, out-of-storage indexes, the
// unknown opcode and the three zero-mass velocity cases. Random segments then
// set cell count and coefficients, load a full grid and mix loads, reads and
// steps. Read beats are checked against typed row values or an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
    import swsten_pkg::*;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
    localparam longint unsigned HALF_LSB = 64'd8388608;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [Q_W-1:0] mass;
        logic signed [Q_W-1:0] momentum;
        logic signed [Q_W-1:0] velocity;
    } cell_t;

    typedef struct {
        logic [OP_W-1:0]       op;
        logic [CIDX_W-1:0]     idx;
        logic signed [Q_W-1:0] mass;
        logic signed [Q_W-1:0] momentum;
        logic                  typed;
        cell_t                 want;
    } row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COEF_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    shallow_water_1d_stencil_step_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model of the solver state: two mass/momentum buffers selected by
    // now_sel, plus flags that track which entries have ever been written.
    logic signed [Q_W-1:0] mass_buf [2][DEPTH];
    logic signed [Q_W-1:0] mom_buf [2][DEPTH];
    logic signed [Q_W-1:0] vel_mem [DEPTH];
    logic signed [Q_W-1:0] flux_mem [DEPTH];
    bit                    written [2][DEPTH];
    int                    now_sel = 0;
    logic [CNT_W-1:0]      cnt_reg = RST_CELL_COUNT;
    logic [COEF_W-1:0]     step_reg = RST_STEP_COEF;
    logic [COEF_W-1:0]     press_reg = RST_PRESS_COEF;

    cell_t reads_due[$];
    int    mismatches = 0;
    int    beats_checked = 0;
    int    steps_run = 0;
    int    items_sent = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    step_in_flight = 0;

    function automatic logic signed [Q_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return Q_MAX;
        if (v < -64'sd2147483648) return Q_MIN;
        return v[Q_W-1:0];
    endfunction

    // Q8.24 product, round half toward plus infinity.
    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned ma, mb, p;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        p = ma * mb;
        if ((a < 0) != (b < 0)) return -longint'((p + HALF_LSB - 1) >> FRAC);
        return longint'((p + HALF_LSB) >> FRAC);
    endfunction

    function automatic logic signed [Q_W-1:0] fx_div(input longint p, input longint m);
        if (m == 0) return (p > 0) ? Q_MAX : ((p < 0) ? Q_MIN : '0);
        return clamp32((p * 64'sd16777216) / m);
    endfunction

    function automatic int cells_used();
        if (cnt_reg < 2) return 2;
        if (cnt_reg > MAX_CELLS) return MAX_CELLS;
        return int'(cnt_reg);
    endfunction

    task automatic advance_grid();
        int n, a, b;
        longint u, mu, muu, km, kmm, avg, d;
        n = cells_used();
        a = now_sel;
        b = 1 - a;
        mass_buf[a][0] = mass_buf[a][2];
        mass_buf[a][n+1] = mass_buf[a][n-1];
        mom_buf[a][0] = clamp32(-longint'(mom_buf[a][2]));
        mom_buf[a][n+1] = clamp32(-longint'(mom_buf[a][n-1]));
        written[a][0] = 1;
        written[a][n+1] = 1;
        for (int x = 0; x <= n + 1; x++) begin
            u = vel_mem[x];
            mu = clamp32(fx_mul(mass_buf[a][x], u));
            muu = clamp32(fx_mul(mu, u));
            km = clamp32(fx_mul(press_reg, mass_buf[a][x]));
            kmm = clamp32(fx_mul(km, mass_buf[a][x]));
            flux_mem[x] = clamp32(muu + kmm);
        end
        for (int x = 1; x <= n; x++) begin
            avg = (longint'(mom_buf[a][x+1]) + mom_buf[a][x-1]) >>> 1;
            d = longint'(flux_mem[x+1]) - flux_mem[x-1];
            mom_buf[b][x] = clamp32(avg - fx_mul(step_reg, d));
            avg = (longint'(mass_buf[a][x+1]) + mass_buf[a][x-1]) >>> 1;
            d = longint'(mom_buf[a][x+1]) - mom_buf[a][x-1];
            mass_buf[b][x] = clamp32(avg - fx_mul(step_reg, d));
            written[b][x] = 1;
        end
        for (int x = 1; x <= n; x++)
            vel_mem[x] = fx_div(mom_buf[b][x], mass_buf[b][x]);
        now_sel = b;
    endtask

    // Applies one accepted command to the model and returns the read result.
    function automatic cell_t apply_command(input logic [OP_W-1:0] op,
                                            input logic [CIDX_W-1:0] idx,
                                            input logic signed [Q_W-1:0] ms,
                                            input logic signed [Q_W-1:0] mo);
        cell_t r;
        r = '0;
        if (op == OP_LOAD && idx < DEPTH) begin
            mass_buf[now_sel][idx] = ms;
            mom_buf[now_sel][idx] = mo;
            written[now_sel][idx] = 1;
        end else if (op == OP_READ && idx < DEPTH) begin
            r.mass = mass_buf[now_sel][idx];
            r.momentum = mom_buf[now_sel][idx];
            r.velocity = vel_mem[idx];
        end
        return r;
    endfunction

    // Drives one command beat and waits for its acceptance. tvalid is left
    // high so that a following beat can go out back to back.
    task automatic send_command(input logic [OP_W-1:0] op, input logic [CIDX_W-1:0] idx,
                                input logic signed [Q_W-1:0] ms,
                                input logic signed [Q_W-1:0] mo,
                                input bit typed, input cell_t want);
        int gap;
        cell_t r;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'd0, mo, ms, idx};
        forever begin
            @(negedge i_clk);
            if (s_tready) break;
        end
        @(posedge i_clk);
        items_sent++;
        r = apply_command(op, idx, ms, mo);
        if (op == OP_STEP) begin
            advance_grid();
            step_in_flight = 1;
            steps_run++;
        end
        if (op == OP_READ) reads_due.push_back(typed ? want : r);
    endtask

    // Waits until the core is idle: all reads returned and any step finished.
    task automatic drain_core();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reads_due.size() > 0) @(posedge i_clk);
        if (step_in_flight) repeat (80 * (cells_used() + 2) + 100) @(posedge i_clk);
        step_in_flight = 0;
    endtask

    // One write per call; the enable is dropped again before the next one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CELL_COUNT) cnt_reg = val[CNT_W-1:0];
        else if (idx == CFG_STEP_COEF) step_reg = val;
        else if (idx == CFG_PRESS_COEF) press_reg = val;
        @(posedge i_clk);
    endtask

    function automatic logic signed [Q_W-1:0] rand_value(input bit positive);
        if ($urandom_range(0, 3) == 0) return $urandom;
        if (positive) return $urandom_range(32'h0040_0000, 32'h0400_0000);
        return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endfunction

    // One random segment: new settings, a full grid load, then mixed traffic.
    task automatic run_segment(input logic [COEF_W-1:0] n_val, input logic [COEF_W-1:0] c_val,
                               input logic [COEF_W-1:0] k_val, input int n_ops,
                               input int max_steps);
        int n, steps, pick;
        logic [CIDX_W-1:0] idx;
        drain_core();
        write_reg(CFG_CELL_COUNT, n_val);
        write_reg(CFG_STEP_COEF, c_val);
        write_reg(CFG_PRESS_COEF, k_val);
        n = cells_used();
        steps = 0;
        for (int x = 0; x <= n + 1; x++)
            send_command(OP_LOAD, CIDX_W'(x), rand_value(1), rand_value(0), 0, '0);
        for (int i = 0; i < n_ops; i++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) idx = CIDX_W'($urandom_range(DEPTH, 2047));
            else if ($urandom_range(0, 9) == 0) idx = CIDX_W'($urandom_range(0, DEPTH - 1));
            else idx = CIDX_W'($urandom_range(0, n + 1));
            if (pick < 10 && steps < max_steps) begin
                steps++;
                send_command(OP_STEP, CIDX_W'($urandom), $urandom, $urandom, 0, '0);
            end else if (pick < 13) begin
                send_command(OP_UNKNOWN, idx, $urandom, $urandom, 0, '0);
            end else if (pick < 55) begin
                send_command(OP_LOAD, idx, rand_value(1), rand_value(0), 0, '0);
            end else if (idx >= DEPTH || written[now_sel][idx]) begin
                send_command(OP_READ, idx, $urandom, $urandom, 0, '0);
            end
        end
    endtask

    // Receiver: random stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result beats are sampled mid-cycle; a beat seen with valid and ready
    // high is taken at the following rising edge.
    always @(negedge i_clk) begin
        cell_t got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{mass: m_tdata[31:0], momentum: m_tdata[63:32],
                    velocity: m_tdata[95:64]};
            if (reads_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected read beat: %h", m_tdata);
            end else begin
                want = reads_due.pop_front();
                beats_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("read mismatch: mass %h/%h momentum %h/%h velocity %h/%h",
                                 want.mass, got.mass, want.momentum, got.momentum,
                                 want.velocity, got.velocity);
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

    row_t dir_rows [0:20];

    initial begin
        int seg;
        for (int x = 0; x < DEPTH; x++) vel_mem[x] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: four cells, no transport, so zero mass meets
        // positive, negative and zero momentum after one step.
        write_reg(CFG_CELL_COUNT, 31'd4);
        write_reg(CFG_STEP_COEF, 31'd0);
        dir_rows = '{
            '{OP_LOAD, 11'd0, Q_MAX, Q_MIN, 0, '0},
            '{OP_READ, 11'd0, 0, 0, 1, '{Q_MAX, Q_MIN, 32'sd0}},
            '{OP_LOAD, 11'd1025, Q_MIN, Q_MAX, 0, '0},
            '{OP_READ, 11'd1025, 0, 0, 1, '{Q_MIN, Q_MAX, 32'sd0}},
            '{OP_LOAD, 11'd2047, Q_MAX, Q_MAX, 0, '0},
            '{OP_READ, 11'd2047, 0, 0, 1, '0},
            '{OP_READ, 11'd1026, 0, 0, 1, '0},
            '{OP_UNKNOWN, 11'd1, Q_MAX, Q_MAX, 0, '0},
            '{OP_LOAD, 11'd1, 0, 32'sd100, 0, '0},
            '{OP_LOAD, 11'd2, 0, -32'sd100, 0, '0},
            '{OP_LOAD, 11'd3, 0, 32'sd100, 0, '0},
            '{OP_LOAD, 11'd4, 0, -32'sd100, 0, '0},
            '{OP_READ, 11'd2, 0, 0, 1, '{32'sd0, -32'sd100, 32'sd0}},
            '{OP_STEP, 11'd0, 0, 0, 0, '0},
            '{OP_READ, 11'd1, 0, 0, 1, '0},
            '{OP_READ, 11'd2, 0, 0, 1, '{32'sd0, 32'sd100, Q_MAX}},
            '{OP_READ, 11'd3, 0, 0, 1, '{32'sd0, -32'sd100, Q_MIN}},
            '{OP_READ, 11'd4, 0, 0, 0, '0},
            '{OP_STEP, 11'd0, 0, 0, 0, '0},
            '{OP_READ, 11'd1025, 0, 0, 0, '0},
            '{OP_READ, 11'd3, 0, 0, 0, '0}
        };
        foreach (dir_rows[i])
            send_command(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].mass,
                         dir_rows[i].momentum, dir_rows[i].typed, dir_rows[i].want);

        // Extreme settings: smallest grid with full-scale, then zero coefficients,
        // then the largest grid once, reached through a clamped count.
        run_segment(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 20, 3);
        run_segment(31'd1, 31'd0, 31'd0, 12, 2);
        run_segment(31'd2047, RST_STEP_COEF, RST_PRESS_COEF, 6, 1);

        // Random segments cycle through the idling phases.
        seg = 0;
        while (items_sent < 1800) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            run_segment($urandom_range(2, 16),
                        ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2000000),
                        ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 200000),
                        $urandom_range(30, 60), 4);
            seg++;
        end
        drain_core();
        repeat (50) @(posedge i_clk);

        $display("Sent %0d command beats including %0d grid steps; checked %0d read beats.",
                 items_sent, steps_run, beats_checked);
        $display("Covered %0d random segments with varied cell counts and coefficients.", seg);
        if (mismatches == 0 && reads_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d reads outstanding", mismatches, reads_due.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
